// ----- src/assert_macros.svh -----
// Assertion macros used by the checker of the frame allocator.
// Depends on nothing; ASSERT_CLK expects clk and rst_n in scope, ASSERT_ALWAYS clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fba_pkg.sv -----
// Package for the frame bitmap allocator: beat types, command codes and defaults.
// Depends on nothing; used by the top level and the checker.
package fba_pkg;

  localparam int CMD_W    = 2;
  localparam int FRAME_W  = 12;
  localparam int FCOUNT_W = 13;

  localparam int DEF_MAX_FRAMES = 4096;
  localparam int DEF_WORD_BITS  = 32;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] frame_number;
    logic               writable;
    logic               kernel_page;
  } fba_in_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] given_frame;
    logic               present;
    logic               rw_bit;
    logic               user_bit;
    logic               in_use;
  } fba_out_t;

endpackage

// ----- src/fba_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/frame_bitmap_allocator_unit.sv -----
// Top level of the first-fit physical frame allocator over a used bitmap.
// Depends on fba_pkg and fba_ram.
//
// The block keeps one used bit per frame in a RAM of WORD_BITS-bit words and
// handles one beat at a time; WORD_BITS must be a power of two. After reset it
// clears all MAP_WORDS words of the RAM (128 by default), one word a cycle,
// before the first beat is taken. An allocate scans the bitmap one word per cycle
// through the single RAM read port until it finds a free bit, passes the frame
// limit or runs out of words. Free and test take the word and bit straight from
// the frame number; free then does one read and one write, test one read only.
// Rejected commands skip the RAM and go straight to S_EMIT. A result that cannot
// be loaded because the previous one is still stalled holds the block until the
// output register frees. The next beat is taken in the cycle after a result is
// loaded, while that result still sits in the output register.
module frame_bitmap_allocator_unit #(
  parameter int MAX_FRAMES = fba_pkg::DEF_MAX_FRAMES,
  parameter int WORD_BITS  = fba_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fba_pkg::fba_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fba_pkg::fba_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [fba_pkg::FCOUNT_W-1:0]    cfg_wdata
);

  import fba_pkg::*;

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int BASE_BITS = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
  localparam int CMP_W     = (BASE_BITS > FCOUNT_W) ? BASE_BITS : FCOUNT_W;

  localparam logic [AW-1:0]        LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [CMP_W-1:0]     MAX_C     = CMP_W'(MAX_FRAMES);
  localparam logic [CMP_W-1:0]     WB_C      = CMP_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE_BIT   = {{(WORD_BITS - 1){1'b0}}, 1'b1};
  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_UPD, S_SCAN, S_SCHK, S_ALC, S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic                 wr_r, wr_nxt;
  logic                 kern_r, kern_nxt;
  logic [AW-1:0]        word_r, word_nxt;
  logic [CMP_W-1:0]     base_r, base_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  fba_out_t             res_r, res_nxt;
  fba_out_t             out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FCOUNT_W-1:0]  frame_count_r, frame_count_nxt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [CMP_W-1:0]     lim;
  logic [BW-1:0]        first_zero;
  logic [CMP_W-1:0]     cand;
  logic                 in_range;

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign lim      = (CMP_W'(frame_count_r) > MAX_C) ? MAX_C : CMP_W'(frame_count_r);
  assign cand     = base_r + CMP_W'(bit_r);
  assign in_range = (CMP_W'(in_data.frame_number) < MAX_C);

  always_comb begin
    first_zero = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        first_zero = BW'(i);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    wr_nxt          = wr_r;
    kern_nxt        = kern_r;
    word_nxt        = word_r;
    base_nxt        = base_r;
    bit_nxt         = bit_r;
    clr_nxt         = clr_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    frame_count_nxt = cfg_we ? cfg_wdata : frame_count_r;
    ram_we          = 1'b0;
    ram_waddr       = word_r;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = word_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          wr_nxt    = in_data.writable;
          kern_nxt  = in_data.kernel_page;
          word_nxt  = AW'(in_data.frame_number >> BW);
          bit_nxt   = in_data.frame_number[BW-1:0];
          base_nxt  = '0;
          res_nxt   = '0;
          state_nxt = S_EMIT;
          case (in_data.command)
            CMD_ALLOC: begin
              if (in_data.frame_number == '0) begin
                word_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (in_data.frame_number != '0) begin
                res_nxt.ok = 1'b1;
                if (in_range) begin
                  state_nxt = S_FETCH;
                end
              end
            end
            CMD_TEST: begin
              if (in_range) begin
                state_nxt = S_FETCH;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (cmd_r == CMD_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(ONE_BIT << bit_r);
        end else begin
          res_nxt.in_use = ram_rdata[bit_r];
        end
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (base_r >= lim) begin
          state_nxt = S_EMIT;
        end else if (ram_rdata != FULL_WORD) begin
          bit_nxt   = first_zero;
          state_nxt = S_ALC;
        end else if (word_r == LAST_WORD) begin
          state_nxt = S_EMIT;
        end else begin
          word_nxt  = word_r + AW'(1);
          base_nxt  = base_r + WB_C;
          ram_re    = 1'b1;
          ram_raddr = word_r + AW'(1);
        end
      end
      S_ALC: begin
        if (cand < lim) begin
          ram_we              = 1'b1;
          ram_wdata           = ram_rdata | (ONE_BIT << bit_r);
          res_nxt.ok          = 1'b1;
          res_nxt.given_frame = FRAME_W'(cand);
          res_nxt.present     = 1'b1;
          res_nxt.rw_bit      = wr_r;
          res_nxt.user_bit    = !kern_r;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
      frame_count_r <= FCOUNT_RESET;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      out_valid_r   <= out_valid_nxt;
      frame_count_r <= frame_count_nxt;
    end
    cmd_r  <= cmd_nxt;
    wr_r   <= wr_nxt;
    kern_r <= kern_nxt;
    word_r <= word_nxt;
    base_r <= base_nxt;
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ----- src/fba_checker.sv -----
// Port-level checker for the frame allocator, bound to the top level.
// Depends on fba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input fba_pkg::fba_out_t            out_data
);

  import fba_pkg::*;

  logic out_stall;
  logic entry_bits;
  logic alloc_ok;

  assign out_stall  = out_valid && !out_ready;
  assign entry_bits = out_data.present || out_data.rw_bit || out_data.user_bit ||
                      (out_data.given_frame != '0);
  assign alloc_ok   = out_data.ok && out_data.present;

  // A result beat that is held back keeps its contents.
  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(out_data), "stalled beat changed")

  // Once a beat is taken the block is not ready again in the cycle after.
  `ASSERT_CLK(a_busy, in_valid && in_ready |=> !in_ready, "ready right after a beat")

  // Page-entry bits only ever come with a successful allocation.
  `ASSERT_CLK(a_entry_needs_ok, out_valid && entry_bits |-> alloc_ok, "entry bits without success")

  // A test result never reports success at the same time.
  `ASSERT_CLK(a_test_no_ok, out_valid && out_data.in_use |-> !out_data.ok, "in_use and ok both set")

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (.*);
